// ===== src/positional_sequential_list_core_defines.svh =====
// Assertion macros shared by the list core checker.
`ifndef POSITIONAL_SEQUENTIAL_LIST_CORE_DEFINES_SVH
`define POSITIONAL_SEQUENTIAL_LIST_CORE_DEFINES_SVH

// Overlapping implication, sampled on clk, off during reset.
`define PLSL_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PLSL_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Implication after a fixed number of cycles.
`define PLSL_ASSERT_LAT(label, ante, n, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
    else $error(msg);

`endif

// ===== src/plsl_pkg.sv =====
// Shared constants, action codes and the cell command type of the list core.
`timescale 1ns / 1ps

package plsl_pkg;

  localparam int DEPTH  = 128;
  localparam int DATA_W = 32;
  localparam int ACT_W  = 2;
  localparam int POS_W  = 8;
  localparam int IDX_W  = 7;
  localparam int CNT_W  = 8;

  // first-match tree: groups of GRP cells, then a pick over the groups
  localparam int GRP    = 8;
  localparam int LGRP   = $clog2(GRP);
  localparam int NGRP   = DEPTH / GRP;
  localparam int NGRP_W = IDX_W - LGRP;

  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd2;
  localparam logic [ACT_W-1:0] ACT_UPDATE = 2'd3;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic              wr;
    logic [ACT_W-1:0]  act;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] val;
    logic [CNT_W-1:0]  cnt;
  } cell_cmd_t;

endpackage

// ===== src/positional_sequential_list_core.sv =====
// Top level of the positional list: controller, cell row and match finder.
`timescale 1ns / 1ps

// A list of up to 128 signed 32-bit entries held in a row of cells, empty
// after reset. Pulse start with an action while busy is low; the request is
// taken at that edge and busy rises. Every request gives exactly one result,
// shown for a single cycle with out_valid high; there is no way to hold it
// off, so sample it in that cycle. busy is low again in the result cycle, so
// a new request can be taken at the edge that ends it. A request passes the
// cell row registers (shift, write and key compare in all cells at once),
// the per-group register of the two-level first-match tree over the compare
// flags, whose group pick is combinational, and then the output register.
// Insert, remove and update take the same time as search.
module positional_sequential_list_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [plsl_pkg::ACT_W-1:0]         in_action,
  input  logic [plsl_pkg::POS_W-1:0]         in_position,
  input  logic signed [plsl_pkg::DATA_W-1:0] in_value,
  output logic                               out_valid,
  output logic                               out_ok,
  output logic [plsl_pkg::IDX_W-1:0]         out_found_index,
  output logic [plsl_pkg::CNT_W-1:0]         out_count
);
  import plsl_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_TREE = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [ACT_W-1:0]  act_r;
  logic [POS_W-1:0]  pos_r;
  logic [DATA_W-1:0] val_r;
  logic              ok_r;
  logic              op_ok;
  logic              out_valid_r;
  logic              out_ok_r;
  logic [IDX_W-1:0]  out_idx_r;
  logic [CNT_W-1:0]  out_cnt_r;

  cell_cmd_t         cmd;
  logic [DATA_W-1:0] data_w [DEPTH];
  logic [DEPTH-1:0]  match_w;
  logic              hit;
  logic [IDX_W-1:0]  hit_idx;

  logic accept;
  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  // action legality against the current count
  always_comb begin
    case (act_r)
      ACT_INSERT: op_ok = (cnt_r < CNT_W'(DEPTH)) && (pos_r <= POS_W'(cnt_r));
      ACT_REMOVE: op_ok = pos_r < POS_W'(cnt_r);
      ACT_UPDATE: op_ok = pos_r < POS_W'(cnt_r);
      default:    op_ok = 1'b0;
    endcase
  end

  // broadcast to the cells
  always_comb begin
    cmd.wr  = (state_r == S_EXEC) && op_ok;
    cmd.act = act_r;
    cmd.pos = pos_r;
    cmd.val = val_r;
    cmd.cnt = cnt_r;
  end

  // count after the action
  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.wr) begin
      if (act_r == ACT_INSERT) begin
        cnt_nxt = cnt_r + 1'b1;
      end else if (act_r == ACT_REMOVE) begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (start) state_nxt = S_EXEC;
      S_EXEC:  state_nxt = S_TREE;
      S_TREE:  state_nxt = S_DONE;
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= (state_r == S_DONE);
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r <= in_action;
      pos_r <= in_position;
      val_r <= in_value;
    end
    if (state_r == S_EXEC) begin
      ok_r <= op_ok;
    end
    if (state_r == S_DONE) begin
      if (act_r == ACT_SEARCH) begin
        out_ok_r  <= hit;
        out_idx_r <= hit ? hit_idx : '0;
      end else begin
        out_ok_r  <= ok_r;
        out_idx_r <= '0;
      end
      out_cnt_r <= cnt_r;
    end
  end

  // row of cells, each linked to its neighbors, zero past either end
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] left_d;
    logic [DATA_W-1:0] right_d;
    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = data_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = data_w[i+1];
    end
    plsl_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .idx        (POS_W'(i)),
      .left_data  (left_d),
      .right_data (right_d),
      .data_o     (data_w[i]),
      .match_o    (match_w[i])
    );
  end

  plsl_prio u_prio (
    .clk   (clk),
    .match (match_w),
    .hit   (hit),
    .index (hit_idx)
  );

  assign out_valid       = out_valid_r;
  assign out_ok          = out_ok_r;
  assign out_found_index = out_idx_r;
  assign out_count       = out_cnt_r;

endmodule

// ===== src/plsl_cell.sv =====
// One list cell: holds an entry, shifts with its neighbors, compares to the key.
`timescale 1ns / 1ps

module plsl_cell (
  input  logic                      clk,
  input  plsl_pkg::cell_cmd_t       cmd,
  input  logic [plsl_pkg::POS_W-1:0]  idx,
  input  logic [plsl_pkg::DATA_W-1:0] left_data,
  input  logic [plsl_pkg::DATA_W-1:0] right_data,
  output logic [plsl_pkg::DATA_W-1:0] data_o,
  output logic                      match_o
);
  import plsl_pkg::*;

  logic [DATA_W-1:0] data_r, data_nxt;
  logic              match_r, match_nxt;

  // shift or write, depending on where this cell sits against the position
  always_comb begin
    data_nxt = data_r;
    if (cmd.wr) begin
      case (cmd.act)
        ACT_INSERT: begin
          if (idx > cmd.pos) begin
            data_nxt = left_data;
          end else if (idx == cmd.pos) begin
            data_nxt = cmd.val;
          end
        end
        ACT_REMOVE: begin
          if (idx >= cmd.pos) begin
            data_nxt = right_data;
          end
        end
        ACT_UPDATE: begin
          if (idx == cmd.pos) begin
            data_nxt = cmd.val;
          end
        end
        default: data_nxt = data_r;
      endcase
    end
  end

  // only live cells can match
  assign match_nxt = (idx < POS_W'(cmd.cnt)) && (data_r == cmd.val);

  always_ff @(posedge clk) begin
    data_r  <= data_nxt;
    match_r <= match_nxt;
  end

  assign data_o  = data_r;
  assign match_o = match_r;

endmodule

// ===== src/plsl_prio.sv =====
// Two-level first-match finder over the row of cell match flags.
`timescale 1ns / 1ps

module plsl_prio (
  input  logic                       clk,
  input  logic [plsl_pkg::DEPTH-1:0] match,
  output logic                       hit,
  output logic [plsl_pkg::IDX_W-1:0] index
);
  import plsl_pkg::*;

  logic [NGRP-1:0] grp_any_r, grp_any_nxt;
  logic [LGRP-1:0] grp_idx_r [NGRP];
  logic [LGRP-1:0] grp_idx_nxt [NGRP];

  // lowest set flag inside each group
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_any_nxt[g] = |match[g*GRP +: GRP];
      grp_idx_nxt[g] = '0;
      for (int j = GRP - 1; j >= 0; j--) begin
        if (match[g*GRP + j]) begin
          grp_idx_nxt[g] = LGRP'(j);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_any_r <= grp_any_nxt;
    for (int g = 0; g < NGRP; g++) begin
      grp_idx_r[g] <= grp_idx_nxt[g];
    end
  end

  // lowest group with a hit
  always_comb begin
    hit   = 1'b0;
    index = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (grp_any_r[g]) begin
        hit   = 1'b1;
        index = {NGRP_W'(g), grp_idx_r[g]};
      end
    end
  end

endmodule

// ===== src/plsl_checker.sv =====
// Port-level checks for the list core, bound to the top level.
`timescale 1ns / 1ps
`include "positional_sequential_list_core_defines.svh"

module plsl_props (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               start,
  input logic                               busy,
  input logic                               out_valid,
  input logic                               out_ok,
  input logic [plsl_pkg::IDX_W-1:0]         out_found_index,
  input logic [plsl_pkg::CNT_W-1:0]         out_count
);
  import plsl_pkg::*;

  // every accepted request is followed by a result strobe
  `PLSL_ASSERT_LAT(a_latency, start && !busy, 4, out_valid, "result missing after request")
  // results are single-cycle strobes
  `PLSL_ASSERT_NXT(a_strobe, out_valid, !out_valid, "result strobe longer than one cycle")
  // a nonzero index only comes with a search hit
  `PLSL_ASSERT_IMP(a_index, out_valid && (out_found_index != '0), out_ok, "index without hit")
  // count never exceeds the capacity
  `PLSL_ASSERT_IMP(a_count, out_valid, out_count <= CNT_W'(DEPTH), "count above capacity")

endmodule

bind positional_sequential_list_core plsl_props u_plsl_props (.*);
